// ===== src/shabh_pkg.sv =====
package shabh_pkg;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HASH,
		ST_PAD,
		ST_PADW,
		ST_LEN,
		ST_LENW,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic append;
		logic pad;
		logic len;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic pad_two;
		logic done;
		logic idx_last;
	} sts_t;

	localparam int unsigned BLOCK_BITS = 512;
	localparam int unsigned PAD_LIMIT = 448;
	localparam int unsigned ROUNDS = 64;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ===== src/shabh_ctrl.sv =====
module shabh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_item,
	input  logic             out_stall,
	input  shabh_pkg::sts_t  sts,
	output shabh_pkg::cmd_t  cmd,
	output logic             in_stall,
	output logic             out_valid
);
	import shabh_pkg::*;

	state_t state_q, state_d;
	logic   last_q;
	logic   in_acc;
	logic   out_acc;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;

	// State register and the pending end-of-message flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				last_q <= last_item;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (sts.full) state_d = ST_HASH;
					else if (last_item) state_d = ST_PAD;
				end
			end
			ST_HASH: begin
				if (sts.done) state_d = last_q ? ST_PAD : ST_IDLE;
			end
			ST_PAD:  state_d = sts.pad_two ? ST_PADW : ST_LENW;
			ST_PADW: begin
				if (sts.done) state_d = ST_LEN;
			end
			ST_LEN:  state_d = ST_LENW;
			ST_LENW: begin
				if (sts.done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_acc && sts.idx_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd.append = in_acc;
		cmd.pad    = (state_q == ST_PAD);
		cmd.len    = (state_q == ST_LEN);
		cmd.emit   = out_acc;
	end

endmodule

// ===== src/shabh_dp.sv =====
module shabh_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  shabh_pkg::cmd_t  cmd,
	input  logic [7:0]       data_byte,
	input  logic [2:0]       skip_bits,
	input  logic [3:0]       take_bits,
	output shabh_pkg::sts_t  sts,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	import shabh_pkg::*;

	logic [31:0]  chain_q [8];
	logic [511:0] blk_q;
	logic [63:0]  cnt_q;
	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [5:0]   rnd_q;
	logic         busy_q;
	logic         fin_q;
	logic [2:0]   oidx_q;

	logic [3:0]   room;
	logic [3:0]   take_eff;
	logic [7:0]   bits;
	logic [8:0]   pos;
	logic [9:0]   pend;
	logic [511:0] nb, lb, pb, lenb;
	logic         full;

	// Saturate the take and align the taken bits at the top of the word.
	assign room     = 4'd8 - {1'b0, skip_bits};
	assign take_eff = (take_bits > room) ? room : take_bits;
	assign bits     = data_byte << skip_bits;
	assign pos      = cnt_q[8:0];
	assign pend     = {1'b0, pos} + {6'd0, take_eff};
	assign full     = pend[9];

	// Block with the new bits, and the bits that spill into the next block.
	always_comb begin
		logic [9:0] p;
		nb = blk_q;
		lb = '0;
		for (int i = 0; i < 8; i++) begin
			p = {1'b0, pos} + 10'(i);
			if (4'(i) < take_eff && bits[7 - i]) begin
				if (!p[9]) nb[9'd511 - p[8:0]] = 1'b1;
				else lb[9'd511 - p[8:0]] = 1'b1;
			end
		end
		pb = blk_q;
		pb[9'd511 - pos] = 1'b1;
		lenb = pb;
		lenb[63:0] = cnt_q;
	end

	// Round logic of the compression.
	logic [31:0] s1, chv, t1, s0, mj, t2, ws0, ws1, wn;
	assign s1  = {e_q[5:0], e_q[31:6]} ^ {e_q[10:0], e_q[31:11]} ^ {e_q[24:0], e_q[31:25]};
	assign chv = (e_q & f_q) ^ (~e_q & g_q);
	assign t1  = h_q + s1 + chv + RK[rnd_q] + w_q[0];
	assign s0  = {a_q[1:0], a_q[31:2]} ^ {a_q[12:0], a_q[31:13]} ^ {a_q[21:0], a_q[31:22]};
	assign mj  = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
	assign t2  = s0 + mj;
	assign ws0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
	assign ws1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
		^ (w_q[14] >> 10);
	assign wn  = w_q[0] + ws0 + w_q[9] + ws1;

	// Block buffer, bit count, schedule window, working and chain registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= IV[i];
			blk_q  <= '0;
			cnt_q  <= '0;
			rnd_q  <= '0;
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			oidx_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (cmd.append) begin
				cnt_q <= cnt_q + {60'd0, take_eff};
				if (full) begin
					for (int i = 0; i < 16; i++) w_q[i] <= nb[511 - 32 * i -: 32];
					blk_q <= lb;
				end else begin
					blk_q <= nb;
				end
			end
			if (cmd.pad) begin
				if (pos >= 9'(PAD_LIMIT)) begin
					for (int i = 0; i < 16; i++) w_q[i] <= pb[511 - 32 * i -: 32];
				end else begin
					for (int i = 0; i < 16; i++) w_q[i] <= lenb[511 - 32 * i -: 32];
				end
				blk_q <= '0;
			end
			if (cmd.len) begin
				for (int i = 0; i < 15; i++) w_q[i] <= 32'd0;
				w_q[14] <= cnt_q[63:32];
				w_q[15] <= cnt_q[31:0];
			end
			// Start a compression from the current chain value.
			if ((cmd.append && full) || cmd.pad || cmd.len) begin
				a_q <= chain_q[0]; b_q <= chain_q[1]; c_q <= chain_q[2]; d_q <= chain_q[3];
				e_q <= chain_q[4]; f_q <= chain_q[5]; g_q <= chain_q[6]; h_q <= chain_q[7];
				rnd_q  <= '0;
				busy_q <= 1'b1;
			end
			if (busy_q) begin
				h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
				d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
				w_q[15] <= wn;
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'(ROUNDS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q) begin
				chain_q[0] <= chain_q[0] + a_q; chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q; chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q; chain_q[5] <= chain_q[5] + f_q;
				chain_q[6] <= chain_q[6] + g_q; chain_q[7] <= chain_q[7] + h_q;
			end
			// Step through the digest words and start over after the last one.
			if (cmd.emit) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7) begin
					for (int i = 0; i < 8; i++) chain_q[i] <= IV[i];
					blk_q <= '0;
					cnt_q <= '0;
				end
			end
		end
	end

	assign sts.full     = full;
	assign sts.pad_two  = (pos >= 9'(PAD_LIMIT));
	assign sts.done     = fin_q;
	assign sts.idx_last = (oidx_q == 3'd7);

	assign digest_word = chain_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

endmodule

// ===== src/sha256_bitstring_hash.sv =====
// SHA-256 of a bit string fed one byte per word. An input word is taken
// whenever in_stall is low; a word that completes a 512-bit block starts a
// compression on its accepting edge and then keeps the input stalled through
// the 64 rounds, one per cycle, and the chain update after them. A last word adds
// one or two more compressions (two when fewer than 65 bits are left in the
// block), each started from its own control state and then run the same way.
// After that the eight digest words leave one per cycle, word 0 first, as the
// output side takes them. The round unit is the only shared resource.
module sha256_bitstring_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  skip_bits,
	input  logic [3:0]  take_bits,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import shabh_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	shabh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_item (last_item),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	// Packing, padding and compression datapath.
	shabh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.skip_bits   (skip_bits),
		.take_bits   (take_bits),
		.sts         (sts),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule

// ===== sim/sha_digest_checker.sv =====
module sha_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  skip_bits,
	input  logic [3:0]  take_bits,
	input  logic        last_item,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          pending_words
);

	import shabh_pkg::*;

	typedef struct {
		logic [31:0] digest;
		logic [2:0]  index;
		logic        final_word;
	} digest_entry_t;

	// Shadow copy of the hash state.
	logic [31:0] chain [8];
	logic [31:0] blk [16];
	logic [63:0] msg_bits;
	digest_entry_t digest_q [$];

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Restart a message from the standard initial value.
	task automatic clear_message();
		for (int i = 0; i < 8; i++) chain[i] = IV[i];
		for (int i = 0; i < 16; i++) blk[i] = '0;
		msg_bits = '0;
	endtask

	// One SHA-256 compression of the block buffer into the chain, then an empty buffer.
	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ RK[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
		for (int i = 0; i < 16; i++) blk[i] = '0;
	endtask

	task automatic set_bit(input logic [8:0] pos);
		blk[pos[8:5]][31 - pos[4:0]] = 1'b1;
	endtask

	// Absorb one input word; a last word pads, finishes and queues the digest.
	task automatic absorb_word(input logic [7:0] byte_in, input logic [2:0] skip,
			input logic [3:0] take, input logic fin);
		int count;
		logic [8:0] pos;
		digest_entry_t entry;
		count = take;
		if (count > 8 - skip) count = 8 - skip;
		for (int i = 0; i < count; i++) begin
			if (byte_in[7 - skip - i]) set_bit(msg_bits[8:0]);
			msg_bits++;
			if (msg_bits[8:0] == 9'd0) compress();
		end
		if (fin) begin
			pos = msg_bits[8:0];
			set_bit(pos);
			if (pos >= PAD_LIMIT) compress();
			blk[14] = msg_bits[63:32];
			blk[15] = msg_bits[31:0];
			compress();
			for (int i = 0; i < 8; i++) begin
				entry.digest = chain[i];
				entry.index = i[2:0];
				entry.final_word = (i == 7);
				digest_q.push_back(entry);
			end
			clear_message();
		end
	endtask

	initial begin
		fail_count = 0;
		pending_words = 0;
		clear_message();
	end

	// Track accepted words on both channels.
	always @(posedge clk) begin
		digest_entry_t exp_word;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					$error("digest word with nothing expected: %h", digest_word);
					fail_count++;
				end else begin
					exp_word = digest_q.pop_front();
					if (digest_word !== exp_word.digest) begin
						$error("digest_word expected %h actual %h", exp_word.digest, digest_word);
						fail_count++;
					end
					if (word_index !== exp_word.index) begin
						$error("word_index expected %0d actual %0d", exp_word.index, word_index);
						fail_count++;
					end
					if (last_word !== exp_word.final_word) begin
						$error("last_word expected %0d actual %0d", exp_word.final_word,
							last_word);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				absorb_word(data_byte, skip_bits, take_bits, last_item);
		end
		pending_words = digest_q.size();
	end

endmodule

// ===== sim/testbench.sv =====
module testbench;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic [2:0]  skip_bits = '0;
	logic [3:0]  take_bits = '0;
	logic        last_item = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          fail_count;
	int          pending_words;
	int          sent_words = 0;
	int          idle_cycles = 0;
	int          cycle_count = 0;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_START = 1000;
	localparam int HOLD_LEN = 600;

	sha256_bitstring_hash u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .skip_bits(skip_bits), .take_bits(take_bits),
		.last_item(last_item),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	sha_digest_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .skip_bits(skip_bits), .take_bits(take_bits),
		.last_item(last_item),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word),
		.fail_count(fail_count), .pending_words(pending_words)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// Offer one word, hold it until taken, then maybe leave a gap.
	task automatic send_word(input logic [7:0] b, input logic [2:0] s,
			input logic [3:0] t, input logic l);
		int gap;
		in_valid <= 1'b1;
		data_byte <= b;
		skip_bits <= s;
		take_bits <= t;
		last_item <= l;
		do @(posedge clk); while (in_stall);
		sent_words++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_words != 0);
	endtask

	// A random message, mostly whole bytes, sometimes with odd skips and takes.
	task automatic send_message(input int len);
		logic [2:0] s;
		logic [3:0] t;
		for (int i = 0; i < len; i++) begin
			s = 3'd0;
			t = 4'd8;
			if ($urandom_range(9) == 0) begin
				s = 3'($urandom_range(7));
				t = 4'($urandom_range(8));
			end
			send_word(8'($urandom_range(255)), s, t, i == len - 1);
		end
	endtask

	// Receiver: random stalls in phases, one long hold-off.
	initial begin
		int mode;
		mode = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count == HOLD_START) begin
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
			end
			if (cycle_count % 200 == 0) mode = $urandom_range(2);
			if (mode == 0) out_stall <= 1'b0;
			else if (mode == 1) out_stall <= ($urandom_range(3) == 0);
			else out_stall <= ($urandom_range(30) == 0) ? 1'b1 : ($urandom_range(1) == 0);
		end
	end

	// Watchdog on cycles with no accepted word on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message.
		send_word(8'h00, 3'd0, 4'd0, 1'b1);
		// Three whole bytes.
		send_word(8'h61, 3'd0, 4'd8, 1'b0);
		send_word(8'h62, 3'd0, 4'd8, 1'b0);
		send_word(8'h63, 3'd0, 4'd8, 1'b1);
		// A single bit taken after the widest skip.
		send_word(8'h01, 3'd7, 4'd1, 1'b1);
		// Oversized take, skip on a later word, zero takes.
		send_word(8'hff, 3'd3, 4'd8, 1'b0);
		send_word(8'h00, 3'd5, 4'd2, 1'b0);
		send_word(8'hff, 3'd0, 4'd0, 1'b0);
		send_word(8'ha5, 3'd1, 4'd7, 1'b0);
		send_word(8'h00, 3'd0, 4'd0, 1'b1);
		// Extreme bytes.
		send_word(8'hff, 3'd0, 4'd8, 1'b0);
		send_word(8'h00, 3'd0, 4'd8, 1'b0);
		send_word(8'hff, 3'd6, 4'd3, 1'b1);
		wait_drained();

		// Random messages; some land near the padding limit.
		while (sent_words < 280) begin
			if ($urandom_range(3) == 0) send_message($urandom_range(63, 54));
			else send_message($urandom_range(12, 1));
			if ($urandom_range(5) == 0) wait_drained();
		end
		wait_drained();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_words == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
